// ===== rtl/bus_transaction_statistics_assert.svh =====
// Assertion macros shared by the statistics block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef BUS_TRANSACTION_STATISTICS_ASSERT_SVH
`define BUS_TRANSACTION_STATISTICS_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define BTS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("bus_transaction_statistics: invariant violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define BTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bus_transaction_statistics: sequence violated");

`endif

// ===== rtl/bts_pkg.sv =====
package bts_pkg;

    localparam int DATA_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int BANK_DEPTH = 13;
    localparam int IDX_W      = $clog2(BANK_DEPTH);

    typedef logic [1:0]        t_kind;
    typedef logic [1:0]        t_outcome;
    typedef logic [2:0]        t_eclass;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DATA_W-1:0] t_data;
    typedef logic [BYTE_W-1:0] t_byte;

    localparam t_byte MAX_BLOCK_BYTES = 8'd255;
    localparam t_idx  BANK_DEPTH_IDX  = IDX_W'(BANK_DEPTH);

    localparam t_kind KIND_RECORD = 2'd0;
    localparam t_kind KIND_CLEAR  = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;

    localparam t_outcome OUTCOME_COMPLETED = 2'd0;
    localparam t_outcome OUTCOME_FAILED    = 2'd1;

    localparam t_eclass ECLASS_TIMEOUT   = 3'd1;
    localparam t_eclass ECLASS_NACK      = 3'd2;
    localparam t_eclass ECLASS_ARB_LOST  = 3'd3;
    localparam t_eclass ECLASS_PEC       = 3'd4;
    localparam t_eclass ECLASS_BUS_ERROR = 3'd5;

    localparam t_idx IDX_COMPLETED  = 4'd0;
    localparam t_idx IDX_FAILED     = 4'd1;
    localparam t_idx IDX_TIMEOUT    = 4'd2;
    localparam t_idx IDX_RETRIED    = 4'd3;
    localparam t_idx IDX_BYTES_SENT = 4'd4;
    localparam t_idx IDX_BYTES_RECV = 4'd5;
    localparam t_idx IDX_MIN_TIME   = 4'd6;
    localparam t_idx IDX_MAX_TIME   = 4'd7;
    localparam t_idx IDX_AVG_TIME   = 4'd8;
    localparam t_idx IDX_NACK       = 4'd9;
    localparam t_idx IDX_ARB_LOST   = 4'd10;
    localparam t_idx IDX_PEC        = 4'd11;
    localparam t_idx IDX_BUS_ERROR  = 4'd12;

    typedef struct packed {
        t_kind    kind;
        t_outcome outcome;
        logic     is_read_type;
        t_data    duration;
        t_byte    byte_count;
        t_eclass  error_class;
        logic     was_retried;
        t_idx     counter_index;
    } t_in_word;

endpackage

// ===== rtl/bts_if.sv =====
interface bts_in_if;
    logic              valid;
    logic              ready;
    bts_pkg::t_kind    kind;
    bts_pkg::t_outcome outcome;
    logic              is_read_type;
    bts_pkg::t_data    duration;
    bts_pkg::t_byte    byte_count;
    bts_pkg::t_eclass  error_class;
    logic              was_retried;
    bts_pkg::t_idx     counter_index;

    modport source (
        output valid, kind, outcome, is_read_type, duration, byte_count,
               error_class, was_retried, counter_index,
        input  ready
    );
    modport sink (
        input  valid, kind, outcome, is_read_type, duration, byte_count,
               error_class, was_retried, counter_index,
        output ready
    );
endinterface

interface bts_out_if;
    logic           valid;
    logic           ready;
    bts_pkg::t_data read_value;

    modport source (output valid, read_value, input ready);
    modport sink (input valid, read_value, output ready);
endinterface

// ===== rtl/bus_transaction_statistics.sv =====
// Bus transaction statistics bank with thirteen 32-bit counters.
// The i_in channel takes one word per transaction event: a record word
// updates the counters, a clear word zeroes the whole bank, and a read
// word asks for one counter by index.
// The o_out channel returns exactly one word for every input word, in
// order. It carries the selected counter for a read word whose index is
// below thirteen, and zero for every other word.
// An accepted word is held in an input register; when it advances, the
// bank is updated and the result is written to an output register.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its word and the
// input register fills; i_in.ready drops only when both are occupied.
// A read word sees every update made by the words accepted before it.
// Reset is synchronous and active low: it empties both registers and
// clears every counter to zero.
module bus_transaction_statistics (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bts_in_if.sink        i_in,
    bts_out_if.source     o_out
);

    logic              r_in_valid;
    bts_pkg::t_in_word r_in;
    logic              r_out_valid;
    bts_pkg::t_data    r_out_value;
    bts_pkg::t_data    r_bank [bts_pkg::BANK_DEPTH];

    bts_pkg::t_data    n_bank [bts_pkg::BANK_DEPTH];
    bts_pkg::t_data    n_out_value;

    logic              w_advance;
    logic              w_in_ready;
    bts_pkg::t_byte    w_bytes;
    logic [bts_pkg::DATA_W:0] w_avg_sum;
    logic              w_first;

    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.read_value = r_out_value;

    assign w_bytes   = (r_in.byte_count > bts_pkg::MAX_BLOCK_BYTES) ?
                       bts_pkg::MAX_BLOCK_BYTES : r_in.byte_count;
    assign w_avg_sum = {1'b0, r_bank[bts_pkg::IDX_AVG_TIME]} + {1'b0, r_in.duration};
    assign w_first   = (r_bank[bts_pkg::IDX_COMPLETED] + 32'd1) == 32'd1;

    always_comb begin
        n_bank      = r_bank;
        n_out_value = '0;
        if (w_advance) begin
            unique case (r_in.kind)
                bts_pkg::KIND_RECORD: begin
                    if (r_in.outcome == bts_pkg::OUTCOME_COMPLETED) begin
                        n_bank[bts_pkg::IDX_COMPLETED] = r_bank[bts_pkg::IDX_COMPLETED] + 32'd1;
                        if (w_first) begin
                            n_bank[bts_pkg::IDX_MIN_TIME] = r_in.duration;
                            n_bank[bts_pkg::IDX_MAX_TIME] = r_in.duration;
                            n_bank[bts_pkg::IDX_AVG_TIME] = r_in.duration;
                        end else begin
                            if (r_in.duration < r_bank[bts_pkg::IDX_MIN_TIME]) begin
                                n_bank[bts_pkg::IDX_MIN_TIME] = r_in.duration;
                            end
                            if (r_in.duration > r_bank[bts_pkg::IDX_MAX_TIME]) begin
                                n_bank[bts_pkg::IDX_MAX_TIME] = r_in.duration;
                            end
                            n_bank[bts_pkg::IDX_AVG_TIME] = w_avg_sum[bts_pkg::DATA_W:1];
                        end
                        if (r_in.is_read_type) begin
                            n_bank[bts_pkg::IDX_BYTES_RECV] = r_bank[bts_pkg::IDX_BYTES_RECV]
                                + {{(bts_pkg::DATA_W-bts_pkg::BYTE_W){1'b0}}, w_bytes};
                        end else begin
                            n_bank[bts_pkg::IDX_BYTES_SENT] = r_bank[bts_pkg::IDX_BYTES_SENT]
                                + {{(bts_pkg::DATA_W-bts_pkg::BYTE_W){1'b0}}, w_bytes};
                        end
                    end else if (r_in.outcome == bts_pkg::OUTCOME_FAILED) begin
                        n_bank[bts_pkg::IDX_FAILED] = r_bank[bts_pkg::IDX_FAILED] + 32'd1;
                        unique case (r_in.error_class)
                            bts_pkg::ECLASS_TIMEOUT: begin
                                n_bank[bts_pkg::IDX_TIMEOUT] = r_bank[bts_pkg::IDX_TIMEOUT] + 32'd1;
                            end
                            bts_pkg::ECLASS_NACK: begin
                                n_bank[bts_pkg::IDX_NACK] = r_bank[bts_pkg::IDX_NACK] + 32'd1;
                            end
                            bts_pkg::ECLASS_ARB_LOST: begin
                                n_bank[bts_pkg::IDX_ARB_LOST] = r_bank[bts_pkg::IDX_ARB_LOST]
                                    + 32'd1;
                            end
                            bts_pkg::ECLASS_PEC: begin
                                n_bank[bts_pkg::IDX_PEC] = r_bank[bts_pkg::IDX_PEC] + 32'd1;
                            end
                            bts_pkg::ECLASS_BUS_ERROR: begin
                                n_bank[bts_pkg::IDX_BUS_ERROR] = r_bank[bts_pkg::IDX_BUS_ERROR]
                                    + 32'd1;
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_in.was_retried) begin
                        n_bank[bts_pkg::IDX_RETRIED] = r_bank[bts_pkg::IDX_RETRIED] + 32'd1;
                    end
                end
                bts_pkg::KIND_CLEAR: begin
                    n_bank = '{default: '0};
                end
                bts_pkg::KIND_READ: begin
                    if (r_in.counter_index < bts_pkg::BANK_DEPTH_IDX) begin
                        n_out_value = r_bank[r_in.counter_index];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bank      <= '{default: '0};
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_bank <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_in_ready) begin
            r_in.kind          <= i_in.kind;
            r_in.outcome       <= i_in.outcome;
            r_in.is_read_type  <= i_in.is_read_type;
            r_in.duration      <= i_in.duration;
            r_in.byte_count    <= i_in.byte_count;
            r_in.error_class   <= i_in.error_class;
            r_in.was_retried   <= i_in.was_retried;
            r_in.counter_index <= i_in.counter_index;
        end
        if (w_advance) begin
            r_out_value <= n_out_value;
        end
    end

`include "bus_transaction_statistics_assert.svh"

    // The minimum never exceeds the average, and the average never exceeds the maximum.
    `BTS_ASSERT_ALWAYS(a_min_le_avg,
        r_bank[bts_pkg::IDX_MIN_TIME] <= r_bank[bts_pkg::IDX_AVG_TIME])
    `BTS_ASSERT_ALWAYS(a_avg_le_max,
        r_bank[bts_pkg::IDX_AVG_TIME] <= r_bank[bts_pkg::IDX_MAX_TIME])
    // Input is refused only while a word waits in the input register.
    `BTS_ASSERT_ALWAYS(a_stall_has_word, w_in_ready || r_in_valid)
    // A processed clear word leaves the completed and failed counters at zero.
    `BTS_ASSERT_NEXT(a_clear_zeroes,
        w_advance && (r_in.kind == bts_pkg::KIND_CLEAR),
        (r_bank[bts_pkg::IDX_COMPLETED] == '0) && (r_bank[bts_pkg::IDX_FAILED] == '0))
    // Only read words produce a nonzero result.
    `BTS_ASSERT_NEXT(a_non_read_zero,
        w_advance && (r_in.kind != bts_pkg::KIND_READ),
        r_out_valid && (r_out_value == '0))

endmodule

// ===== test/bus_transaction_statistics_tb.sv =====
`timescale 1ns / 1ps

module bus_transaction_statistics_tb;

    import bts_pkg::*;

    localparam t_kind    KIND_UNUSED       = 2'd3;
    localparam t_outcome OUTCOME_NEITHER   = 2'd2;
    localparam t_outcome OUTCOME_UNDEFINED = 2'd3;
    localparam t_eclass  ECLASS_OTHER      = 3'd0;

    localparam int RANDOM_WORDS    = 1800;
    localparam int CALM_WORDS      = 300;
    localparam int PHASE_WORDS     = 150;
    localparam int END_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT  = 1000;

    class counter_bank_tracker;
        t_data bank [BANK_DEPTH];
        t_data expected_read_values [$];
        int    errors;

        function new();
            errors = 0;
            clear_bank();
        endfunction

        function void clear_bank();
            foreach (bank[i]) begin
                bank[i] = '0;
            end
        endfunction

        function int pending();
            return expected_read_values.size();
        endfunction

        function void note_word(t_in_word w);
            t_data           value;
            t_data           bytes;
            logic [DATA_W:0] avg_sum;
            value = '0;
            case (w.kind)
                KIND_RECORD: begin
                    bytes = (w.byte_count > MAX_BLOCK_BYTES) ? t_data'(MAX_BLOCK_BYTES)
                                                             : t_data'(w.byte_count);
                    if (w.outcome == OUTCOME_COMPLETED) begin
                        bank[IDX_COMPLETED] += 1;
                        if (bank[IDX_COMPLETED] == 1) begin
                            bank[IDX_MIN_TIME] = w.duration;
                            bank[IDX_MAX_TIME] = w.duration;
                            bank[IDX_AVG_TIME] = w.duration;
                        end else begin
                            if (w.duration < bank[IDX_MIN_TIME]) begin
                                bank[IDX_MIN_TIME] = w.duration;
                            end
                            if (w.duration > bank[IDX_MAX_TIME]) begin
                                bank[IDX_MAX_TIME] = w.duration;
                            end
                            // The average is the halved 33-bit sum of the old average and
                            // the new duration.
                            avg_sum = {1'b0, bank[IDX_AVG_TIME]} + {1'b0, w.duration};
                            bank[IDX_AVG_TIME] = avg_sum[DATA_W:1];
                        end
                        if (w.is_read_type) begin
                            bank[IDX_BYTES_RECV] += bytes;
                        end else begin
                            bank[IDX_BYTES_SENT] += bytes;
                        end
                    end else if (w.outcome == OUTCOME_FAILED) begin
                        bank[IDX_FAILED] += 1;
                        case (w.error_class)
                            ECLASS_TIMEOUT:   bank[IDX_TIMEOUT] += 1;
                            ECLASS_NACK:      bank[IDX_NACK] += 1;
                            ECLASS_ARB_LOST:  bank[IDX_ARB_LOST] += 1;
                            ECLASS_PEC:       bank[IDX_PEC] += 1;
                            ECLASS_BUS_ERROR: bank[IDX_BUS_ERROR] += 1;
                            default: ;
                        endcase
                    end
                    if (w.was_retried) begin
                        bank[IDX_RETRIED] += 1;
                    end
                end
                KIND_CLEAR: begin
                    clear_bank();
                end
                KIND_READ: begin
                    if (w.counter_index < BANK_DEPTH_IDX) begin
                        value = bank[w.counter_index];
                    end
                end
                default: ;
            endcase
            expected_read_values.push_back(value);
        endfunction

        function void check_read_value(t_data actual);
            t_data expected;
            if (expected_read_values.size() == 0) begin
                $display("%0t: read_value arrived with nothing expected, expected none, actual %h",
                         $time, actual);
                errors++;
            end else begin
                expected = expected_read_values.pop_front();
                if (actual !== expected) begin
                    $display("%0t: read_value mismatch, expected %h, actual %h",
                             $time, expected, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   gap_odds;
    int   stall_odds;
    int   quiet_cycles;

    counter_bank_tracker tracker;

    bts_in_if  in_if ();
    bts_out_if out_if ();

    bus_transaction_statistics dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
    end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Accepted words are predicted before results are checked, so a word and its
    // result could never be confused even if they met on one edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                tracker.note_word(t_in_word'{in_if.kind, in_if.outcome, in_if.is_read_type,
                                             in_if.duration, in_if.byte_count,
                                             in_if.error_class, in_if.was_retried,
                                             in_if.counter_index});
            end
            if (out_if.valid && out_if.ready) begin
                tracker.check_read_value(out_if.read_value);
            end
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL bus_transaction_statistics");
            $finish;
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!calm && stall_left == 0 && stall_odds != 0
                    && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic int sender_gap();
        if (calm || gap_odds == 0) begin
            return 0;
        end
        if ($urandom_range(1, gap_odds) == 1) begin
            return $urandom_range(1, 16);
        end
        return 0;
    endfunction

    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        w.is_read_type = 1'($urandom_range(0, 1));
        w.was_retried  = 1'($urandom_range(0, 1));
        w.error_class  = t_eclass'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
            0:       w.duration = '0;
            1:       w.duration = '1;
            2:       w.duration = t_data'($urandom_range(0, 255));
            default: w.duration = t_data'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0) begin
            w.byte_count = MAX_BLOCK_BYTES;
        end else begin
            w.byte_count = t_byte'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            w.counter_index = t_idx'($urandom_range(BANK_DEPTH, 15));
        end else begin
            w.counter_index = t_idx'($urandom_range(0, BANK_DEPTH - 1));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            w.outcome = OUTCOME_COMPLETED;
        end else if (pick < 8) begin
            w.outcome = OUTCOME_FAILED;
        end else if (pick == 8) begin
            w.outcome = OUTCOME_NEITHER;
        end else begin
            w.outcome = OUTCOME_UNDEFINED;
        end
        pick = $urandom_range(0, 199);
        if (pick < 120) begin
            w.kind = KIND_RECORD;
        end else if (pick < 192) begin
            w.kind = KIND_READ;
        end else if (pick < 196) begin
            w.kind = KIND_CLEAR;
        end else begin
            w.kind = KIND_UNUSED;
        end
        return w;
    endfunction

    function automatic t_in_word record_word(t_outcome outcome, t_data duration,
                                             t_byte byte_count, logic is_read_type,
                                             t_eclass error_class, logic was_retried);
        t_in_word w;
        w = random_word();
        w.kind         = KIND_RECORD;
        w.outcome      = outcome;
        w.duration     = duration;
        w.byte_count   = byte_count;
        w.is_read_type = is_read_type;
        w.error_class  = error_class;
        w.was_retried  = was_retried;
        return w;
    endfunction

    function automatic t_in_word read_word(t_idx counter_index);
        t_in_word w;
        w = random_word();
        w.kind          = KIND_READ;
        w.counter_index = counter_index;
        return w;
    endfunction

    function automatic t_in_word clear_word();
        t_in_word w;
        w = random_word();
        w.kind = KIND_CLEAR;
        return w;
    endfunction

    task automatic put_word(input t_in_word w);
        in_if.kind          <= w.kind;
        in_if.outcome       <= w.outcome;
        in_if.is_read_type  <= w.is_read_type;
        in_if.duration      <= w.duration;
        in_if.byte_count    <= w.byte_count;
        in_if.error_class   <= w.error_class;
        in_if.was_retried   <= w.was_retried;
        in_if.counter_index <= w.counter_index;
    endtask

    // Valid is only lowered when a gap follows, so it never falls and rises in one step.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        put_word(w);
        in_if.valid <= 1'b1;
        do @(posedge clk); while (!in_if.ready);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    initial begin
        t_in_word w;
        tracker      = new();
        calm         = 1'b0;
        gap_odds     = 4;
        stall_odds   = 4;
        quiet_cycles = 0;
        rst_n       <= 1'b0;
        in_if.valid <= 1'b0;
        put_word('0);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_word(read_word(IDX_AVG_TIME));
        send_word(record_word(OUTCOME_COMPLETED, '1, MAX_BLOCK_BYTES, 1'b1, ECLASS_OTHER, 1'b1));
        send_word(record_word(OUTCOME_COMPLETED, '1, '0, 1'b0, ECLASS_TIMEOUT, 1'b0));
        send_word(record_word(OUTCOME_COMPLETED, '0, MAX_BLOCK_BYTES, 1'b0, ECLASS_NACK, 1'b1));
        for (int c = 0; c < 8; c++) begin
            send_word(record_word(OUTCOME_FAILED, t_data'($urandom), t_byte'($urandom),
                                  1'(c), t_eclass'(c), 1'(c >> 1)));
        end
        send_word(record_word(OUTCOME_NEITHER, '1, MAX_BLOCK_BYTES, 1'b1, ECLASS_PEC, 1'b1));
        send_word(record_word(OUTCOME_UNDEFINED, '0, MAX_BLOCK_BYTES, 1'b0, ECLASS_BUS_ERROR,
                              1'b1));
        w = random_word();
        w.kind = KIND_UNUSED;
        send_word(w);
        send_word(read_word(IDX_MIN_TIME));
        send_word(read_word(IDX_MAX_TIME));
        send_word(read_word(IDX_AVG_TIME));
        send_word(read_word(IDX_BYTES_RECV));
        send_word(read_word(IDX_BYTES_SENT));
        send_word(read_word(IDX_RETRIED));
        send_word(read_word(BANK_DEPTH_IDX));
        send_word(read_word('1));
        send_word(clear_word());
        send_word(read_word(IDX_MIN_TIME));
        send_word(record_word(OUTCOME_COMPLETED, 32'h8000_0001, 8'h01, 1'b1, ECLASS_OTHER,
                              1'b0));
        send_word(read_word(IDX_AVG_TIME));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_WORDS == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    default: gap_odds = 8;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_odds = 0;
                    1:       stall_odds = 3;
                    default: stall_odds = 8;
                endcase
            end
            if (n == RANDOM_WORDS / 2) begin
                drain_results();
            end
            if (n == RANDOM_WORDS - CALM_WORDS) begin
                calm = 1'b1;
            end
            send_word(random_word());
        end

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASS bus_transaction_statistics");
        end else begin
            $display("FAIL bus_transaction_statistics");
        end
        $finish;
    end

endmodule
